// File: hw/rtl/assert_macros.svh
// assertion helpers for the effective-address unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds outside reset
`define ASSERT_ON(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("lbl failed");

`endif

// File: hw/rtl/m68k_ea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package m68k_ea_pkg;

  typedef enum logic [1:0] {
    OP_RESOLVE = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_SET_PC  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DREG = 2'd0,
    KIND_AREG = 2'd1,
    KIND_MEM  = 2'd2
  } kind_e;

  localparam logic [2:0] MODE_DREG  = 3'd0;
  localparam logic [2:0] MODE_AREG  = 3'd1;
  localparam logic [2:0] MODE_IND   = 3'd2;
  localparam logic [2:0] MODE_POST  = 3'd3;
  localparam logic [2:0] MODE_PRE   = 3'd4;
  localparam logic [2:0] MODE_D16   = 3'd5;
  localparam logic [2:0] MODE_IDX   = 3'd6;
  localparam logic [2:0] MODE_EXT   = 3'd7;

  localparam logic [2:0] SUB_ABS_W  = 3'd0;
  localparam logic [2:0] SUB_ABS_L  = 3'd1;
  localparam logic [2:0] SUB_PC_D16 = 3'd2;
  localparam logic [2:0] SUB_PC_IDX = 3'd3;
  localparam logic [2:0] SUB_IMM    = 3'd4;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_LONG  = 2'd2;

  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = 1;

  // one word after decode, as it waits for the back end
  typedef struct packed {
    op_e         op;
    logic [2:0]  mode;
    logic [2:0]  rnum;
    logic [1:0]  size;
    logic [15:0] ext;
    logic [15:0] ext2;
    logic [31:0] value;
  } cmd_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/m68k_ea_front.sv
`timescale 1ns / 1ps
`default_nettype none
// accepts words, packs them and keeps a short queue for the back end
module m68k_ea_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [2:0]         mode_i,
  input  wire logic [2:0]         reg_req_i,
  input  wire logic [1:0]         size_i,
  input  wire logic [15:0]        ext_word_i,
  input  wire logic [15:0]        ext_word2_i,
  input  wire logic [31:0]        write_value_i,
  output logic                    cmd_valid_o,
  input  wire logic               cmd_ready_i,
  output m68k_ea_pkg::cmd_t       cmd_o
);

  m68k_ea_pkg::cmd_t         mem_q [m68k_ea_pkg::QDEPTH];
  logic [m68k_ea_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [m68k_ea_pkg::QPTR_W:0]   cnt_q, cnt_d;
  logic push, pop;
  m68k_ea_pkg::cmd_t cin;

  always_comb begin
    cin.op    = m68k_ea_pkg::op_e'(op_i);
    cin.mode  = mode_i;
    cin.rnum  = reg_req_i;
    // size code 3 behaves as long
    cin.size  = size_i[1] ? m68k_ea_pkg::SIZE_LONG : size_i;
    cin.ext   = ext_word_i;
    cin.ext2  = ext_word2_i;
    cin.value = write_value_i;
  end

  assign in_ready_o  = (cnt_q != (m68k_ea_pkg::QPTR_W+1)'(m68k_ea_pkg::QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (m68k_ea_pkg::QPTR_W+1)'(push) - (m68k_ea_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cin;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/m68k_ea_back.sv
`timescale 1ns / 1ps
`default_nettype none
// register file, address arithmetic and the output register
module m68k_ea_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire m68k_ea_pkg::cmd_t  cmd_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              target_kind_o,
  output logic                    bad_mode_o,
  output logic [31:0]             location_o,
  output logic [31:0]             read_value_o,
  output logic [31:0]             pc_after_o
);

  logic [31:0] dreg_q [8];
  logic [31:0] areg_q [8];
  logic [31:0] pc_q, pc_d;
  logic        ov_q;
  logic [1:0]  kind_q, kind_d;
  logic        bad_q, bad_d;
  logic [31:0] loc_q, loc_d, rdv_q, rdv_d, pco_q;

  logic        go;
  logic [31:0] an, stepv, xv, idx_sum, merged;
  logic        a_we, d_we;
  logic [31:0] a_wd;
  logic [3:0]  xn;

  assign cmd_ready_o = !ov_q || out_ready_i;
  assign go = cmd_valid_i && cmd_ready_o;

  always_comb begin
    an = areg_q[cmd_i.rnum];
    if (cmd_i.size == m68k_ea_pkg::SIZE_BYTE) begin
      // byte step on the stack pointer keeps it even
      stepv = (cmd_i.rnum == 3'd7) ? 32'd2 : 32'd1;
    end else if (cmd_i.size == m68k_ea_pkg::SIZE_WORD) begin
      stepv = 32'd2;
    end else begin
      stepv = 32'd4;
    end
    xn = cmd_i.ext[15:12];
    xv = xn[3] ? areg_q[xn[2:0]] : dreg_q[xn[2:0]];
    if (!cmd_i.ext[11]) begin
      xv = m68k_ea_pkg::sext16(xv[15:0]);
    end
    idx_sum = m68k_ea_pkg::sext8(cmd_i.ext[7:0]) + xv;
    unique case (cmd_i.size)
      m68k_ea_pkg::SIZE_BYTE: merged = {dreg_q[cmd_i.rnum][31:8], cmd_i.value[7:0]};
      m68k_ea_pkg::SIZE_WORD: merged = {dreg_q[cmd_i.rnum][31:16], cmd_i.value[15:0]};
      default:                merged = cmd_i.value;
    endcase
  end

  always_comb begin
    kind_d = m68k_ea_pkg::KIND_DREG;
    bad_d  = 1'b0;
    loc_d  = '0;
    rdv_d  = '0;
    pc_d   = pc_q;
    a_we   = 1'b0;
    a_wd   = cmd_i.value;
    d_we   = 1'b0;
    unique case (cmd_i.op)
      m68k_ea_pkg::OP_RESOLVE: begin
        kind_d = m68k_ea_pkg::KIND_MEM;
        unique case (cmd_i.mode)
          m68k_ea_pkg::MODE_DREG: begin
            kind_d = m68k_ea_pkg::KIND_DREG;
            loc_d  = {29'd0, cmd_i.rnum};
          end
          m68k_ea_pkg::MODE_AREG: begin
            kind_d = m68k_ea_pkg::KIND_AREG;
            loc_d  = {29'd0, cmd_i.rnum};
          end
          m68k_ea_pkg::MODE_IND: loc_d = an;
          m68k_ea_pkg::MODE_POST: begin
            loc_d = an;
            a_we  = 1'b1;
            a_wd  = an + stepv;
          end
          m68k_ea_pkg::MODE_PRE: begin
            a_we  = 1'b1;
            a_wd  = an - stepv;
            loc_d = a_wd;
          end
          m68k_ea_pkg::MODE_D16: begin
            loc_d = an + m68k_ea_pkg::sext16(cmd_i.ext);
            pc_d  = pc_q + 32'd2;
          end
          m68k_ea_pkg::MODE_IDX: begin
            loc_d = an + idx_sum;
            pc_d  = pc_q + 32'd2;
          end
          default: begin
            unique case (cmd_i.rnum)
              m68k_ea_pkg::SUB_ABS_W: begin
                loc_d = m68k_ea_pkg::sext16(cmd_i.ext);
                pc_d  = pc_q + 32'd2;
              end
              m68k_ea_pkg::SUB_ABS_L: begin
                loc_d = {cmd_i.ext, cmd_i.ext2};
                pc_d  = pc_q + 32'd4;
              end
              m68k_ea_pkg::SUB_PC_D16: begin
                loc_d = pc_q + m68k_ea_pkg::sext16(cmd_i.ext);
                pc_d  = pc_q + 32'd2;
              end
              m68k_ea_pkg::SUB_PC_IDX: begin
                loc_d = pc_q + idx_sum;
                pc_d  = pc_q + 32'd2;
              end
              m68k_ea_pkg::SUB_IMM: begin
                // byte immediate sits in the odd byte
                loc_d = (cmd_i.size == m68k_ea_pkg::SIZE_BYTE) ? pc_q + 32'd1 : pc_q;
                pc_d  = pc_q + ((cmd_i.size[1]) ? 32'd4 : 32'd2);
              end
              default: bad_d = 1'b1;
            endcase
          end
        endcase
      end
      m68k_ea_pkg::OP_WRITE, m68k_ea_pkg::OP_READ: begin
        if (cmd_i.mode[2:1] != 2'b00) begin
          bad_d = 1'b1;
        end else begin
          kind_d = cmd_i.mode[0] ? m68k_ea_pkg::KIND_AREG : m68k_ea_pkg::KIND_DREG;
          loc_d  = {29'd0, cmd_i.rnum};
          if (cmd_i.op == m68k_ea_pkg::OP_WRITE) begin
            a_we = cmd_i.mode[0];
            d_we = !cmd_i.mode[0];
          end else if (!cmd_i.mode[0]) begin
            rdv_d = dreg_q[cmd_i.rnum];
            if (cmd_i.size == m68k_ea_pkg::SIZE_BYTE) begin
              rdv_d = {24'd0, rdv_d[7:0]};
            end else if (cmd_i.size == m68k_ea_pkg::SIZE_WORD) begin
              rdv_d = {16'd0, rdv_d[15:0]};
            end
          end else begin
            rdv_d = an;
            if (cmd_i.size == m68k_ea_pkg::SIZE_WORD) begin
              rdv_d = {16'd0, rdv_d[15:0]};
            end
          end
        end
      end
      default: pc_d = cmd_i.value;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      pc_q <= '0;
      for (int i = 0; i < 8; i++) begin
        dreg_q[i] <= '0;
        areg_q[i] <= '0;
      end
    end else begin
      if (go) begin
        ov_q <= 1'b1;
        pc_q <= pc_d;
        if (a_we) areg_q[cmd_i.rnum] <= a_wd;
        if (d_we) dreg_q[cmd_i.rnum] <= merged;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      kind_q <= kind_d;
      bad_q  <= bad_d;
      loc_q  <= loc_d;
      rdv_q  <= rdv_d;
      pco_q  <= pc_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign target_kind_o = kind_q;
  assign bad_mode_o    = bad_q;
  assign location_o    = loc_q;
  assign read_value_o  = rdv_q;
  assign pc_after_o    = pco_q;

endmodule
`default_nettype wire

// File: hw/rtl/m68k_effective_address_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// effective-address unit: one word per cycle while results are taken, one result per word. an
// accepted word sits in a two-entry queue, then the back end resolves it against the register
// file and program counter and holds the result in an output register. size code 3 acts as
// long.
`include "assert_macros.svh"
module m68k_effective_address_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [2:0]  mode_i,
  input  wire logic [2:0]  reg_req_i,
  input  wire logic [1:0]  size_i,
  input  wire logic [15:0] ext_word_i,
  input  wire logic [15:0] ext_word2_i,
  input  wire logic [31:0] write_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       target_kind_o,
  output logic             bad_mode_o,
  output logic [31:0]      location_o,
  output logic [31:0]      read_value_o,
  output logic [31:0]      pc_after_o
);

  logic              cmd_valid, cmd_ready;
  m68k_ea_pkg::cmd_t cmd;

  m68k_ea_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .mode_i, .reg_req_i, .size_i,
    .ext_word_i, .ext_word2_i, .write_value_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  m68k_ea_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .target_kind_o, .bad_mode_o, .location_o,
    .read_value_o, .pc_after_o
  );

  // a result that is not taken stays put
  `ASSERT_ON(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(location_o))
  // an undefined mode reports a zero address
  `ASSERT_ON(a_bad_zero, clk_i, rst_ni, out_valid_o && bad_mode_o |-> location_o == 32'd0)
  // queue word moves on only when the back end can take it
  `ASSERT_ON(a_q_flow, clk_i, rst_ni, cmd_valid && out_valid_o && !out_ready_i |-> !cmd_ready)
  `ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o || rst_ni)

endmodule
`default_nettype wire
